### design/psd_pkg.sv
// psd_pkg: shared constants and types for the point-to-segment distance pipeline
// no dependencies; imported by psd_div, psd_sqrt and point_segment_distance
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;

    // default coordinate fraction bits (Q2.FRAC_BITS inputs)
    localparam int FRAC_BITS_DEF = 14;

    // fraction bits of the projection ratio h
    localparam int H_BITS = 16;

    // how the projection ratio is formed
    typedef enum logic [1:0] {
        H_SEL_ZERO = 2'd0,
        H_SEL_ONE  = 2'd1,
        H_SEL_DIV  = 2'd2
    } h_sel_t;

endpackage
`default_nettype wire

### design/point_segment_distance.sv
// point_segment_distance: top level of the point-to-segment distance pipeline
// uses psd_pkg, psd_div and psd_sqrt
`timescale 1ns / 1ps
`default_nettype none
// Distance from a query point to a line segment, all coordinates signed
// Q2.FRAC_BITS, result unsigned Q3.FRAC_BITS truncated. The pipeline takes
// one word per clock unless the output stalls and holds no state between
// words. Three stages form differences, products and the dot products, a
// 16-stage divider yields the clamped projection ratio, four stages rebuild
// the offset vector and its squared length, a FRAC_BITS + 6 stage square
// root follows, and an output register ends the chain. A zero-length
// segment gives the distance to its start. A stall on the result side
// freezes the whole pipeline and drops s_ready.
module point_segment_distance #(
    parameter int FRAC_BITS = psd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [FRAC_BITS+1:0] s_point_x,
    input  wire logic signed [FRAC_BITS+1:0] s_point_y,
    input  wire logic signed [FRAC_BITS+1:0] s_seg_start_x,
    input  wire logic signed [FRAC_BITS+1:0] s_seg_start_y,
    input  wire logic signed [FRAC_BITS+1:0] s_seg_end_x,
    input  wire logic signed [FRAC_BITS+1:0] s_seg_end_y,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [FRAC_BITS+2:0]             m_distance
);
    import psd_pkg::*;

    localparam int IN_W   = FRAC_BITS + 2;
    localparam int D_W    = IN_W + 1;
    localparam int P_W    = 2 * D_W;
    localparam int N_W    = P_W + 1;
    localparam int L_W    = D_W + H_BITS + 2;
    localparam int M_W    = L_W - H_BITS;
    localparam int SQ_W   = 2 * M_W + 1;
    localparam int R_W    = M_W + 1;
    localparam int OUT_W  = FRAC_BITS + 3;
    localparam int SIDE_W = 4 * D_W + 2;

    logic en;

    // stage 1: differences
    logic                  v1_reg;
    logic signed [D_W-1:0] px1_reg, py1_reg, dx1_reg, dy1_reg;

    // stage 2: products
    logic                  v2_reg;
    logic signed [P_W-1:0] pxdx2_reg, pydy2_reg, dxdx2_reg, dydy2_reg;
    logic signed [D_W-1:0] px2_reg, py2_reg, dx2_reg, dy2_reg;

    // stage 3: dot products and ratio select
    logic                  v3_reg;
    logic signed [N_W-1:0] num3_reg, den3_reg;
    logic [SIDE_W-1:0]     side3_reg;
    logic signed [N_W-1:0] num_c, den_c;
    h_sel_t                sel_c;

    // divider outputs
    logic                  dv_valid;
    logic [H_BITS-1:0]     dv_quot;
    logic [SIDE_W-1:0]     dv_side;
    logic signed [D_W-1:0] pxd, pyd, dxd, dyd;
    h_sel_t                seld;
    logic [H_BITS:0]       h_c;
    logic signed [H_BITS+1:0] hs_c;

    // stage 4: scaled direction
    logic                  v4_reg;
    logic signed [L_W-1:0] dxh4_reg, dyh4_reg;
    logic signed [D_W-1:0] px4_reg, py4_reg;

    // stage 5: offset magnitudes
    logic                  v5_reg;
    logic [M_W-1:0]        mx5_reg, my5_reg;
    logic signed [L_W-1:0] lx_c, ly_c;
    logic [L_W-1:0]        ax_c, ay_c;

    // stage 6: squares, stage 7: sum
    logic                  v6_reg;
    logic [2*M_W-1:0]      sqx6_reg, sqy6_reg;
    logic                  v7_reg;
    logic [SQ_W-1:0]       sum7_reg;

    // root and output
    logic                  sq_valid;
    logic [R_W-1:0]        sq_root;
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      dist_reg;
    logic [R_W-1:0]        out_max;

    // whole pipeline moves unless the output word is stuck
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign out_max = {{(R_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= dv_valid;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            m_valid_reg <= sq_valid;
        end
    end

    // dot products and ratio select
    always_comb begin
        num_c = {pxdx2_reg[P_W-1], pxdx2_reg} + {pydy2_reg[P_W-1], pydy2_reg};
        den_c = {dxdx2_reg[P_W-1], dxdx2_reg} + {dydy2_reg[P_W-1], dydy2_reg};
        if (num_c <= 0) begin
            sel_c = H_SEL_ZERO;
        end else if (num_c >= den_c) begin
            sel_c = H_SEL_ONE;
        end else begin
            sel_c = H_SEL_DIV;
        end
    end

    // front stages
    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg   <= {s_point_x[IN_W-1], s_point_x} -
                         {s_seg_start_x[IN_W-1], s_seg_start_x};
            py1_reg   <= {s_point_y[IN_W-1], s_point_y} -
                         {s_seg_start_y[IN_W-1], s_seg_start_y};
            dx1_reg   <= {s_seg_end_x[IN_W-1], s_seg_end_x} -
                         {s_seg_start_x[IN_W-1], s_seg_start_x};
            dy1_reg   <= {s_seg_end_y[IN_W-1], s_seg_end_y} -
                         {s_seg_start_y[IN_W-1], s_seg_start_y};
            pxdx2_reg <= px1_reg * dx1_reg;
            pydy2_reg <= py1_reg * dy1_reg;
            dxdx2_reg <= dx1_reg * dx1_reg;
            dydy2_reg <= dy1_reg * dy1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            num3_reg  <= num_c;
            den3_reg  <= den_c;
            side3_reg <= {px2_reg, py2_reg, dx2_reg, dy2_reg, 2'(sel_c)};
        end
    end

    psd_div #(
        .N_W    (N_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .num       (num3_reg),
        .den       (den3_reg),
        .side_in   (side3_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    // clamped projection ratio
    always_comb begin
        {pxd, pyd, dxd, dyd} = dv_side[SIDE_W-1:2];
        seld = h_sel_t'(dv_side[1:0]);
        case (seld)
            H_SEL_ONE: h_c = {1'b1, {H_BITS{1'b0}}};
            H_SEL_DIV: h_c = {1'b0, dv_quot};
            default:   h_c = '0;
        endcase
        hs_c = {1'b0, h_c};
    end

    // offset vector p - h*d, magnitudes truncated to coordinate units
    always_comb begin
        lx_c = {{(L_W-D_W-H_BITS){px4_reg[D_W-1]}}, px4_reg, {H_BITS{1'b0}}} - dxh4_reg;
        ly_c = {{(L_W-D_W-H_BITS){py4_reg[D_W-1]}}, py4_reg, {H_BITS{1'b0}}} - dyh4_reg;
        ax_c = lx_c[L_W-1] ? -lx_c : lx_c;
        ay_c = ly_c[L_W-1] ? -ly_c : ly_c;
    end

    // back stages; the full-width product fills L_W exactly
    always_ff @(posedge aclk) begin
        if (en) begin
            dxh4_reg <= dxd * hs_c;
            dyh4_reg <= dyd * hs_c;
            px4_reg  <= pxd;
            py4_reg  <= pyd;
            mx5_reg  <= ax_c[L_W-1:H_BITS];
            my5_reg  <= ay_c[L_W-1:H_BITS];
            sqx6_reg <= mx5_reg * mx5_reg;
            sqy6_reg <= my5_reg * my5_reg;
            sum7_reg <= {1'b0, sqx6_reg} + {1'b0, sqy6_reg};
        end
    end

    psd_sqrt #(
        .SQ_W (SQ_W),
        .R_W  (R_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .rad       (sum7_reg),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    // output register with saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= (sq_root > out_max) ? {OUT_W{1'b1}} : sq_root[OUT_W-1:0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = dist_reg;

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted word lost at first stage");
    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(v7_reg) && $stable(sum7_reg))
        else $error("pipeline moved during stall");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

### design/psd_div.sv
// psd_div: pipelined restoring divider, one quotient bit per stage
// gives floor(num * 2^H_BITS / den) for 0 < num < den; uses psd_pkg
`timescale 1ns / 1ps
`default_nettype none
module psd_div #(
    parameter int N_W    = 35,
    parameter int SIDE_W = 70
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [N_W-1:0]              num,
    input  wire logic [N_W-1:0]              den,
    input  wire logic [SIDE_W-1:0]           side_in,
    output logic                             out_valid,
    output logic [psd_pkg::H_BITS-1:0]       quot,
    output logic [SIDE_W-1:0]                side_out
);
    import psd_pkg::*;

    logic [H_BITS:0]             vld_reg;
    logic [H_BITS:0][N_W:0]      rem_reg;
    logic [H_BITS:0][N_W-1:0]    den_reg;
    logic [H_BITS:0][H_BITS-1:0] q_reg;
    logic [H_BITS:0][SIDE_W-1:0] side_reg;

    // stage zero is the input word
    assign vld_reg[0]  = in_valid;
    assign rem_reg[0]  = {1'b0, num};
    assign den_reg[0]  = den;
    assign q_reg[0]    = '0;
    assign side_reg[0] = side_in;

    for (genvar k = 0; k < H_BITS; k++) begin : g_stage
        logic [N_W:0] trial;
        logic         ge;

        // shift remainder, try subtracting the divisor
        assign trial = {rem_reg[k][N_W-1:0], 1'b0};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? (trial - {1'b0, den_reg[k]}) : trial;
                den_reg[k+1]  <= den_reg[k];
                q_reg[k+1]    <= {q_reg[k][H_BITS-2:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[H_BITS];
    assign quot      = q_reg[H_BITS];
    assign side_out  = side_reg[H_BITS];

endmodule
`default_nettype wire

### design/psd_sqrt.sv
// psd_sqrt: pipelined integer square root, one root bit per stage
// gives floor(sqrt(rad)); uses psd_pkg
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt #(
    parameter int SQ_W = 39,
    parameter int R_W  = 20
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [SQ_W-1:0] rad,
    output logic                 out_valid,
    output logic [R_W-1:0]       root
);
    import psd_pkg::*;

    localparam int T_W = 2 * R_W + 2;

    logic [R_W:0]            vld_reg;
    logic [R_W:0][T_W-1:0]   rem_reg;
    logic [R_W:0][R_W-1:0]   root_reg;

    assign vld_reg[0]  = in_valid;
    assign rem_reg[0]  = T_W'(rad);
    assign root_reg[0] = '0;

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam int BIT = R_W - 1 - k;
        logic [T_W-1:0] test;
        logic           ge;

        // (2r + 2^i) * 2^i against the running remainder
        assign test = (T_W'(root_reg[k]) << (BIT + 1)) + (T_W'(1) << (2 * BIT));
        assign ge   = (rem_reg[k] >= test);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? (rem_reg[k] - test) : rem_reg[k];
                root_reg[k+1] <= root_reg[k] | (ge ? (R_W'(1) << BIT) : '0);
            end
        end
    end

    assign out_valid = vld_reg[R_W];
    assign root      = root_reg[R_W];

endmodule
`default_nettype wire
